/* rtl/sqis_pkg.sv */
// ----------------------------------------------------------------------------
// SQL query injection scanner - shared definitions
// Keyword table, character codes and byte classification helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package sqis_pkg;

   localparam int NUM_KW     = 9;
   localparam int KW_MAX_LEN = 11;
   // bytes kept behind the current one: longest keyword plus its leading boundary
   localparam int WIN_DEPTH  = KW_MAX_LEN;
   localparam int SEEN_W     = 4;

   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SEMI   = 8'h3B;

   // element d holds the keyword byte expected d places back from its last byte
   typedef logic [KW_MAX_LEN-1:0][7:0] kw_text_type;
   typedef logic [SEEN_W-1:0]          kw_len_type;
   typedef logic [NUM_KW-1:0]          kw_vec_type;

   localparam kw_text_type KW_TEXT [NUM_KW] = '{
      kw_text_type'("EXEC"),
      kw_text_type'("EXECUTE"),
      kw_text_type'("SLEEP"),
      kw_text_type'("DELAY"),
      kw_text_type'("BENCHMARK"),
      kw_text_type'("WAITFOR"),
      kw_text_type'({"XP_", "CMDSHELL"}),
      kw_text_type'("SYSTEM"),
      kw_text_type'("SHUTDOWN")
   };

   localparam kw_len_type KW_LEN [NUM_KW] = '{
      4'd4, 4'd7, 4'd5, 4'd5, 4'd9, 4'd7, 4'd11, 4'd6, 4'd8
   };

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
   endfunction

   function automatic logic [7:0] fold_upper(input logic [7:0] c);
      return (c inside {[8'h61:8'h7A]}) ? (c - 8'd32) : c;
   endfunction

endpackage

`default_nettype wire

/* rtl/sql_query_injection_scanner_top.sv */
// ----------------------------------------------------------------------------
// SQL query injection scanner - top level
// Scans a query one byte per request and returns one verdict per query.
//
// Usage:
//   req_ channel carries one query byte per request; req_final_byte marks the
//   last byte of a query. Exactly one rsp_ request follows each final byte,
//   carrying the overall injection flag and the four individual checks.
//   Bytes are taken into an input register, classified against a window of
//   the previous eleven bytes, and the verdict is written to an output
//   register. One byte is accepted every cycle unless a final byte has to
//   wait, as described below. After a verdict all scan state returns
//   to its reset value, so the next byte opens a new query.
//   Reset empties both registers and clears all scan state; req_ready is low
//   while reset is high. While rsp_ready is low the verdict holds; bytes that
//   are not final keep flowing, and a final byte waits in the input register
//   until the held verdict is taken, which stalls req_ready for that time.
// ----------------------------------------------------------------------------
`default_nettype none

module sql_query_injection_scanner_top (
   input  wire  logic       clock,
   input  wire  logic       reset,
   input  wire  logic       req_valid,
   output       logic       req_ready,
   input  wire  logic [7:0] req_query_byte,
   input  wire  logic       req_final_byte,
   output       logic       rsp_valid,
   input  wire  logic       rsp_ready,
   output       logic       rsp_injection,
   output       logic       rsp_unbalanced_quotes,
   output       logic       rsp_comment_tokens,
   output       logic       rsp_multiple_statements,
   output       logic       rsp_risky_keyword
);
   import sqis_pkg::*;

   logic              s1_valid_ff;
   logic [7:0]        s1_byte_ff;
   logic              s1_final_ff;

   logic [7:0]        recent_ff [WIN_DEPTH];
   logic [7:0]        recent_in [WIN_DEPTH];
   logic [SEEN_W-1:0] bytes_seen_ff, bytes_seen_in;
   logic              open_single_ff, open_single_in;
   logic              open_double_ff, open_double_in;
   logic              inside_lit_ff, inside_lit_in;
   logic              lit_double_ff, lit_double_in;
   logic              semi_ff, semi_in;
   logic [2:0]        sticky_ff, sticky_in;
   kw_vec_type        kw_seen_ff, kw_seen_in;
   kw_vec_type        kw_await_ff, kw_await_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              unbal_ff, unbal_in;
   logic              comm_ff, comm_in;
   logic              multi_ff, multi_in;
   logic              risky_ff, risky_in;

   logic              slot_free;
   logic              s1_advance;
   logic              s1_fire;

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign s1_advance = !s1_final_ff || slot_free;
   assign s1_fire    = s1_valid_ff && s1_advance;
   assign req_ready  = !reset && (!s1_valid_ff || s1_advance);

   always_comb begin
      logic [7:0]  c;
      logic [7:0]  prev;
      logic        has_prev;
      logic        escaped;
      logic        dbl;
      logic        ends_v;
      logic        start_v;
      logic [7:0]  win [WIN_DEPTH+1];
      kw_vec_type  new_await;
      kw_vec_type  new_match;

      c        = s1_byte_ff;
      has_prev = (bytes_seen_ff != '0);
      prev     = recent_ff[0];
      escaped  = has_prev && (prev == CH_BSLASH);
      dbl      = (c == CH_DQUOTE);

      win[0] = c;
      for (int d = 1; d <= WIN_DEPTH; d++) begin
         win[d] = recent_ff[d-1];
      end

      open_single_in = open_single_ff;
      open_double_in = open_double_ff;
      inside_lit_in  = inside_lit_ff;
      lit_double_in  = lit_double_ff;
      semi_in        = semi_ff;
      sticky_in      = sticky_ff;

      // balance check
      if (c == CH_SQUOTE && !open_double_ff) begin
         if (!escaped) open_single_in = !open_single_ff;
      end else if (c == CH_DQUOTE && !open_single_ff) begin
         if (!escaped) open_double_in = !open_double_ff;
      end

      // comment tokens
      if (c == CH_HASH || (has_prev && prev == CH_DASH && c == CH_DASH)
          || (has_prev && prev == CH_SLASH && c == CH_STAR)) begin
         sticky_in[0] = 1'b1;
      end

      // multiple statements
      if (semi_ff && !is_space(c)) sticky_in[1] = 1'b1;
      if (c == CH_SQUOTE || c == CH_DQUOTE) begin
         if (!inside_lit_ff) begin
            inside_lit_in = 1'b1;
            lit_double_in = dbl;
         end else if (dbl == lit_double_ff) begin
            if (!escaped) inside_lit_in = 1'b0;
         end
      end else if (c == CH_SEMI && !inside_lit_ff) begin
         semi_in = 1'b1;
      end

      // risky keywords: close pending word ends, then look for first occurrences
      if (kw_await_ff != '0 && !is_alnum(c)) sticky_in[2] = 1'b1;
      for (int k = 0; k < NUM_KW; k++) begin
         ends_v = ({1'b0, bytes_seen_ff} + 5'd1) >= {1'b0, KW_LEN[k]};
         for (int d = 0; d < KW_MAX_LEN; d++) begin
            if (4'(d) < KW_LEN[k] && fold_upper(win[d]) != KW_TEXT[k][d]) ends_v = 1'b0;
         end
         start_v = (bytes_seen_ff >= KW_LEN[k]) ? !is_alnum(win[KW_LEN[k]]) : 1'b1;
         new_match[k] = ends_v && !kw_seen_ff[k];
         new_await[k] = new_match[k] && start_v;
      end
      kw_seen_in  = kw_seen_ff | new_match;
      kw_await_in = new_await;

      unbal_in = open_single_in || open_double_in;
      comm_in  = sticky_in[0];
      multi_in = sticky_in[1];
      risky_in = sticky_in[2] || (new_await != '0);

      recent_in[0] = c;
      for (int d = 1; d < WIN_DEPTH; d++) begin
         recent_in[d] = recent_ff[d-1];
      end
      bytes_seen_in = (bytes_seen_ff == '1) ? bytes_seen_ff : bytes_seen_ff + 1'b1;

      // end of query: drop all scan state
      if (s1_final_ff) begin
         open_single_in = 1'b0;
         open_double_in = 1'b0;
         inside_lit_in  = 1'b0;
         lit_double_in  = 1'b0;
         semi_in        = 1'b0;
         sticky_in      = '0;
         kw_seen_in     = '0;
         kw_await_in    = '0;
         bytes_seen_in  = '0;
      end
   end

   always_comb begin
      if (s1_fire && s1_final_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_byte_ff  <= req_query_byte;
         s1_final_ff <= req_final_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff  <= '0;
         open_single_ff <= 1'b0;
         open_double_ff <= 1'b0;
         inside_lit_ff  <= 1'b0;
         lit_double_ff  <= 1'b0;
         semi_ff        <= 1'b0;
         sticky_ff      <= '0;
         kw_seen_ff     <= '0;
         kw_await_ff    <= '0;
      end else if (s1_fire) begin
         bytes_seen_ff  <= bytes_seen_in;
         open_single_ff <= open_single_in;
         open_double_ff <= open_double_in;
         inside_lit_ff  <= inside_lit_in;
         lit_double_ff  <= lit_double_in;
         semi_ff        <= semi_in;
         sticky_ff      <= sticky_in;
         kw_seen_ff     <= kw_seen_in;
         kw_await_ff    <= kw_await_in;
      end
   end

   // window reads are qualified by the byte count, so it needs no reset
   always_ff @(posedge clock) begin
      if (s1_fire && !s1_final_ff) begin
         recent_ff <= recent_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_final_ff) begin
         unbal_ff <= unbal_in;
         comm_ff  <= comm_in;
         multi_ff <= multi_in;
         risky_ff <= risky_in;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_unbalanced_quotes   = unbal_ff;
   assign rsp_comment_tokens      = comm_ff;
   assign rsp_multiple_statements = multi_ff;
   assign rsp_risky_keyword       = risky_ff;
   assign rsp_injection           = unbal_ff || comm_ff || multi_ff || risky_ff;

endmodule

`default_nettype wire

/* rtl/sqis_checker.sv */
// ----------------------------------------------------------------------------
// SQL query injection scanner - port checker
// Port-level properties of the scanner, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module sqis_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       req_final_byte,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_injection,
   input wire logic       rsp_unbalanced_quotes,
   input wire logic       rsp_comment_tokens,
   input wire logic       rsp_multiple_statements,
   input wire logic       rsp_risky_keyword
);

   logic any_check;
   assign any_check = rsp_unbalanced_quotes || rsp_comment_tokens
                      || rsp_multiple_statements || rsp_risky_keyword;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_injection)
         && $stable(rsp_unbalanced_quotes) && $stable(rsp_comment_tokens)
         && $stable(rsp_multiple_statements) && $stable(rsp_risky_keyword))
      else $error("held verdict changed");

   a_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_injection == any_check)
      else $error("injection flag disagrees with the individual checks");

   a_verdict_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_final_byte, 2))
      else $error("verdict without a final byte two cycles earlier");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with an empty output register");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("verdict present after reset");

endmodule

bind sql_query_injection_scanner_top sqis_checker u_sqis_checker (
   .clock                   (clock),
   .reset                   (reset),
   .req_valid               (req_valid),
   .req_ready               (req_ready),
   .req_final_byte          (req_final_byte),
   .rsp_valid               (rsp_valid),
   .rsp_ready               (rsp_ready),
   .rsp_injection           (rsp_injection),
   .rsp_unbalanced_quotes   (rsp_unbalanced_quotes),
   .rsp_comment_tokens      (rsp_comment_tokens),
   .rsp_multiple_statements (rsp_multiple_statements),
   .rsp_risky_keyword       (rsp_risky_keyword)
);

`default_nettype wire

/* test/scan_verdict_pkg.sv */
// ----------------------------------------------------------------------------
// SQL injection scanner testbench - verdict tracker
// Works out the verdict of every query from the request bytes that the
// scanner accepts. Returned verdicts are matched against them in order.
// ----------------------------------------------------------------------------
package scan_verdict_pkg;

   localparam int NUM_KEYWORDS = 9;
   localparam int HISTORY      = 12;

   localparam logic [7:0] CHR_TAB       = 8'h09;
   localparam logic [7:0] CHR_CR        = 8'h0D;
   localparam logic [7:0] CHR_SPACE     = 8'h20;
   localparam logic [7:0] CHR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHR_HASH      = 8'h23;
   localparam logic [7:0] CHR_SQUOTE    = 8'h27;
   localparam logic [7:0] CHR_STAR      = 8'h2A;
   localparam logic [7:0] CHR_DASH      = 8'h2D;
   localparam logic [7:0] CHR_SLASH     = 8'h2F;
   localparam logic [7:0] CHR_SEMI      = 8'h3B;
   localparam logic [7:0] CHR_BACKSLASH = 8'h5C;

   typedef struct packed {
      logic injection;
      logic unbalanced;
      logic comment;
      logic multiple;
      logic risky;
   } scan_verdict_type;

   function automatic string keyword_text(input int k);
      case (k)
         0: return "EXEC";
         1: return "EXECUTE";
         2: return "SLEEP";
         3: return "DELAY";
         4: return "BENCHMARK";
         5: return "WAITFOR";
         6: return {"XP_", "CMDSHELL"};
         7: return "SYSTEM";
         default: return "SHUTDOWN";
      endcase
   endfunction

   class verdict_tracker;
      logic [7:0] recent [HISTORY];
      logic [3:0] held;
      bit sq_open;
      bit dq_open;
      bit in_literal;
      bit literal_dq;
      bit semi_seen;
      bit [2:0] sticky;
      bit [NUM_KEYWORDS-1:0] kw_hit;
      bit [NUM_KEYWORDS-1:0] kw_tail;
      scan_verdict_type pending_verdicts [$];
      int failures;

      function new();
         failures = 0;
         clear();
      endfunction

      function void clear();
         foreach (recent[i]) recent[i] = 8'h00;
         held       = 4'd0;
         sq_open    = 1'b0;
         dq_open    = 1'b0;
         in_literal = 1'b0;
         literal_dq = 1'b0;
         semi_seen  = 1'b0;
         sticky     = '0;
         kw_hit     = '0;
         kw_tail    = '0;
      endfunction

      function int outstanding();
         return pending_verdicts.size();
      endfunction

      static function bit blank(input logic [7:0] c);
         return c == CHR_SPACE || (c >= CHR_TAB && c <= CHR_CR);
      endfunction

      static function bit word_char(input logic [7:0] c);
         return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
      endfunction

      static function logic [7:0] upcase(input logic [7:0] c);
         return (c >= "a" && c <= "z") ? c - 8'd32 : c;
      endfunction

      function logic [7:0] back(input logic [7:0] c, input int d);
         if (d == 0) return c;
         if (d > HISTORY) return 8'h00;
         return recent[d-1];
      endfunction

      function bit keyword_ends(input logic [7:0] c, input int k);
         string w;
         w = keyword_text(k);
         if (held + 1 < w.len()) return 1'b0;
         for (int i = 0; i < w.len(); i++)
            if (upcase(back(c, w.len() - 1 - i)) != w[i]) return 1'b0;
         return 1'b1;
      endfunction

      function void take_byte(input logic [7:0] c, input logic fin);
         bit has_prev;
         bit esc;
         bit dbl;
         logic [7:0] prev;
         int n;
         scan_verdict_type v;
         has_prev = held != 4'd0;
         prev     = has_prev ? recent[0] : 8'h00;
         esc      = has_prev && prev == CHR_BACKSLASH;

         if (c == CHR_SQUOTE && !dq_open) begin
            if (!esc) sq_open = !sq_open;
         end else if (c == CHR_DQUOTE && !sq_open) begin
            if (!esc) dq_open = !dq_open;
         end

         if (c == CHR_HASH || (has_prev && prev == CHR_DASH && c == CHR_DASH)
             || (has_prev && prev == CHR_SLASH && c == CHR_STAR))
            sticky[0] = 1'b1;

         if (semi_seen && !blank(c)) sticky[1] = 1'b1;
         if (c == CHR_SQUOTE || c == CHR_DQUOTE) begin
            dbl = c == CHR_DQUOTE;
            if (!in_literal) begin
               in_literal = 1'b1;
               literal_dq = dbl;
            end else if (dbl == literal_dq && !esc) begin
               in_literal = 1'b0;
            end
         end else if (c == CHR_SEMI && !in_literal) begin
            semi_seen = 1'b1;
         end

         // judge the byte after a pending match, then look for new first matches
         if (kw_tail != '0) begin
            if (!word_char(c)) sticky[2] = 1'b1;
            kw_tail = '0;
         end
         for (int k = 0; k < NUM_KEYWORDS; k++) begin
            if (!kw_hit[k] && keyword_ends(c, k)) begin
               n = keyword_text(k).len();
               kw_hit[k] = 1'b1;
               if (held < n || !word_char(back(c, n))) kw_tail[k] = 1'b1;
            end
         end

         if (fin) begin
            v.unbalanced = sq_open || dq_open;
            v.comment    = sticky[0];
            v.multiple   = sticky[1];
            v.risky      = sticky[2] || kw_tail != '0;
            v.injection  = v.unbalanced || v.comment || v.multiple || v.risky;
            pending_verdicts.insert(pending_verdicts.size(), v);
            clear();
         end else begin
            for (int i = HISTORY - 1; i > 0; i--) recent[i] = recent[i-1];
            recent[0] = c;
            if (held != 4'hF) held++;
         end
      endfunction

      function void compare_flag(input string name, input logic want, input logic got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %b, actual %b", $time, name, want, got);
            failures++;
         end
      endfunction

      function void match_verdict(input scan_verdict_type got);
         scan_verdict_type want;
         if (pending_verdicts.size() == 0) begin
            $display("%0t: unexpected verdict, expected none, actual %b", $time, got);
            failures++;
            return;
         end
         want = pending_verdicts.pop_front();
         compare_flag("injection", want.injection, got.injection);
         compare_flag("unbalanced_quotes", want.unbalanced, got.unbalanced);
         compare_flag("comment_tokens", want.comment, got.comment);
         compare_flag("multiple_statements", want.multiple, got.multiple);
         compare_flag("risky_keyword", want.risky, got.risky);
      endfunction
   endclass

endpackage

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// SQL injection scanner testbench - top level
// Streams short directed queries, then random queries built from keywords,
// quotes, escapes, comment tokens, semicolons and raw bytes, with random
// gaps on the request side and random stalls on the verdict side.
// ----------------------------------------------------------------------------
module tb_top;
   import scan_verdict_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int BYTE_TARGET    = 700;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_query_byte = 8'h00;
   logic       req_final_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_injection;
   logic       rsp_unbalanced_quotes;
   logic       rsp_comment_tokens;
   logic       rsp_multiple_statements;
   logic       rsp_risky_keyword;

   bit             steady = 1'b0;
   int             idle_cycles = 0;
   int             bytes_sent = 0;
   logic [7:0]     text [$];
   verdict_tracker tracker = new();

   sql_query_injection_scanner_top dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_query_byte          (req_query_byte),
      .req_final_byte          (req_final_byte),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_injection           (rsp_injection),
      .rsp_unbalanced_quotes   (rsp_unbalanced_quotes),
      .rsp_comment_tokens      (rsp_comment_tokens),
      .rsp_multiple_statements (rsp_multiple_statements),
      .rsp_risky_keyword       (rsp_risky_keyword)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) tracker.take_byte(req_query_byte, req_final_byte);
         if (rsp_valid && rsp_ready)
            tracker.match_verdict({rsp_injection, rsp_unbalanced_quotes, rsp_comment_tokens,
                                   rsp_multiple_statements, rsp_risky_keyword});
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   function automatic int idle_len();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   function automatic void add_byte(input logic [7:0] b);
      text.insert(text.size(), b);
   endfunction

   initial begin
      int stall;
      @(posedge clock);
      forever begin
         stall = idle_len();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   end

   task automatic push_byte(input logic [7:0] b, input logic fin);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_query_byte <= b;
      req_final_byte <= fin;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_text();
      foreach (text[i]) push_byte(text[i], i == text.size() - 1);
      bytes_sent += text.size();
   endtask

   task automatic send_string(input string s);
      text.delete();
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
      send_text();
   endtask

   // hold requests back until every verdict has come
   task automatic wait_for_verdicts();
      req_valid <= 1'b0;
      do @(negedge clock); while (tracker.outstanding() != 0);
      @(posedge clock);
   endtask

   function automatic void compose_query();
      int tokens;
      int r;
      int n;
      string w;
      logic [7:0] ch;
      text.delete();
      r = $urandom_range(0, 99);
      if (r < 10) begin
         repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
         return;
      end
      tokens = (r < 25) ? $urandom_range(10, 24) : $urandom_range(1, 8);
      for (int t = 0; t < tokens; t++) begin
         r = $urandom_range(0, 99);
         if (r < 22) begin
            w = keyword_text($urandom_range(0, NUM_KEYWORDS - 1));
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, w.len()) : w.len();
            for (int i = 0; i < n; i++) begin
               ch = w[i];
               if (ch >= "A" && ch <= "Z" && $urandom_range(0, 1) == 1) ch = ch + 8'd32;
               add_byte(ch);
            end
         end else if (r < 34) begin
            repeat ($urandom_range(1, 3)) begin
               case ($urandom_range(0, 2))
                  0: ch = 8'("0" + $urandom_range(0, 9));
                  1: ch = 8'("A" + $urandom_range(0, 25));
                  default: ch = 8'("a" + $urandom_range(0, 25));
               endcase
               add_byte(ch);
            end
         end else if (r < 46) begin
            add_byte($urandom_range(0, 1) ? CHR_SPACE : 8'($urandom_range(CHR_TAB, CHR_CR)));
         end else if (r < 56) begin
            add_byte($urandom_range(0, 1) ? CHR_SQUOTE : CHR_DQUOTE);
         end else if (r < 61) begin
            add_byte(CHR_BACKSLASH);
         end else if (r < 67) begin
            add_byte(CHR_SEMI);
         end else if (r < 73) begin
            case ($urandom_range(0, 4))
               0: begin
                  add_byte(CHR_DASH);
                  add_byte(CHR_DASH);
               end
               1: begin
                  add_byte(CHR_SLASH);
                  add_byte(CHR_STAR);
               end
               2: add_byte(CHR_HASH);
               3: add_byte(CHR_DASH);
               default: add_byte(CHR_SLASH);
            endcase
         end else if (r < 80) begin
            add_byte(8'($urandom_range(8'h28, 8'h2F)));
         end else if (r < 90) begin
            add_byte(8'($urandom));
         end else begin
            add_byte(8'($urandom_range(128, 255)));
         end
      end
   endfunction

   initial begin
      bit drained;
      drained = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      text.delete();
      add_byte(8'h00);
      send_text();
      text.delete();
      add_byte(8'hFF);
      send_text();
      send_string("x'");
      send_string("\\'\"");
      send_string("--");
      send_string("/*");
      send_string("#");
      send_string(";x");
      send_string("exec");
      send_string("EXECUTE");

      for (int q = 0; bytes_sent < BYTE_TARGET; q++) begin
         steady = (q % 16) >= 12;
         if (!drained && bytes_sent >= BYTE_TARGET / 2) begin
            wait_for_verdicts();
            drained = 1'b1;
         end
         compose_query();
         send_text();
      end
      steady = 1'b0;

      wait_for_verdicts();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.failures == 0 && tracker.outstanding() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
